// File: hw/rtl/quote_aware_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef QUOTE_AWARE_TOKENIZER_DEFINES_SVH
`define QUOTE_AWARE_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define QAT_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define QAT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hw/rtl/qat_pkg.sv
// Shared types, constants and helper functions for the quote-aware tokenizer.
// No dependencies.
package qat_pkg;

	localparam int NEST_BITS = 8;
	localparam int MAP_REGS = 8;
	localparam int ADDR_W = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] PAIR_LOW_BITS = 64'h5555_5555_5555_5555;
	localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [1:0] {
		CLS_ORD   = 2'd0,
		CLS_DROP  = 2'd1,
		CLS_KEEP  = 2'd2,
		CLS_QUOTE = 2'd3
	} char_class_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       string_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       token_first;
		logic       has_byte;
		logic       string_end;
	} out_word_t;

	typedef logic [MAP_REGS-1:0][63:0] class_map_t;

	typedef struct packed {
		class_map_t map;
		logic       has_delim;
	} map_cfg_t;

	typedef struct packed {
		logic       is_bracket;
		logic [7:0] close;
	} bracket_t;

	function automatic bracket_t close_of(input logic [7:0] b);
		bracket_t r;
		r = '0;
		case (b)
			CH_LPAREN: r = '{is_bracket: 1'b1, close: CH_RPAREN};
			CH_LBRACK: r = '{is_bracket: 1'b1, close: CH_RBRACK};
			CH_LBRACE: r = '{is_bracket: 1'b1, close: CH_RBRACE};
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/qat_regs.sv
// APB register file holding the eight 64-bit class map words.
// Depends on qat_pkg.
module qat_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [qat_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready,
	output qat_pkg::map_cfg_t         cfg
);
	import qat_pkg::*;

	class_map_t map_q;
	logic       delim_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (psel && penable && pwrite) begin
			map_q[paddr[ADDR_W-1:3]] <= pwdata;
		end
	end

	always_comb begin
		delim_any = 1'b0;
		for (int i = 0; i < MAP_REGS; i++) begin
			delim_any = delim_any |
				(|((map_q[i] & PAIR_LOW_BITS) ^ ((map_q[i] >> 1) & PAIR_LOW_BITS)));
		end
	end

	assign prdata        = map_q[paddr[ADDR_W-1:3]];
	assign pready        = 1'b1;
	assign cfg.map       = map_q;
	assign cfg.has_delim = delim_any;

endmodule

// File: hw/rtl/qat_front.sv
// Front end: accepts input words, classifies each byte and tracks token and quote state.
// Depends on qat_pkg and quote_aware_tokenizer_defines.svh.
`include "quote_aware_tokenizer_defines.svh"

module qat_front (
	input  logic               clk,
	input  logic               arst_n,
	input  qat_pkg::map_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  qat_pkg::in_word_t  in_data,
	input  logic               space,
	output logic               push,
	output qat_pkg::out_word_t push_word
);
	import qat_pkg::*;

	logic                 tok_q, quote_q;
	logic [7:0]           open_q;
	logic [NEST_BITS-1:0] nest_q;

	logic                 tok_d, quote_d;
	logic [7:0]           open_d;
	logic [NEST_BITS-1:0] nest_d;
	logic                 emit, first, accept;
	logic [7:0]           b;
	char_class_t          cls;
	bracket_t             open_br, b_br;

	assign in_ready = space;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.byte_in;
	assign cls      = char_class_t'(cfg.map[b[7:5]][{b[4:0], 1'b0} +: 2]);
	assign open_br  = close_of(open_q);
	assign b_br     = close_of(b);

	always_comb begin
		tok_d   = tok_q;
		quote_d = quote_q;
		open_d  = open_q;
		nest_d  = nest_q;
		emit    = 1'b0;
		first   = 1'b0;
		if (quote_q) begin
			emit = 1'b1;
			if (open_br.is_bracket) begin
				if (b == open_q) begin
					if (nest_q != NEST_MAX) nest_d = nest_q + 1'b1;
				end else if (b == open_br.close) begin
					if (nest_q != '0) nest_d = nest_q - 1'b1;
					if (nest_d == '0) quote_d = 1'b0;
				end
			end else if (b == open_q) begin
				quote_d = 1'b0;
			end
		end else begin
			case (cls)
				CLS_ORD: begin
					emit  = 1'b1;
					first = !tok_q;
					tok_d = 1'b1;
				end
				CLS_DROP: begin
					tok_d = 1'b0;
				end
				CLS_KEEP: begin
					emit  = 1'b1;
					first = 1'b1;
					tok_d = 1'b0;
				end
				CLS_QUOTE: begin
					emit    = 1'b1;
					first   = !tok_q;
					tok_d   = 1'b1;
					quote_d = 1'b1;
					open_d  = b;
					nest_d  = b_br.is_bracket ? NEST_BITS'(1) : '0;
				end
				default: begin
					tok_d = 1'b0;
				end
			endcase
		end
		// drop all state at string end or when the map has no delimiter
		if (in_data.string_last || !cfg.has_delim) begin
			tok_d   = 1'b0;
			quote_d = 1'b0;
			open_d  = '0;
			nest_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			quote_q <= 1'b0;
			open_q  <= '0;
			nest_q  <= '0;
		end else if (accept) begin
			tok_q   <= tok_d;
			quote_q <= quote_d;
			open_q  <= open_d;
			nest_q  <= nest_d;
		end
	end

	assign push                  = accept && cfg.has_delim && (emit || in_data.string_last);
	assign push_word.token_byte  = emit ? b : 8'd0;
	assign push_word.token_first = emit && first;
	assign push_word.has_byte    = emit;
	assign push_word.string_end  = in_data.string_last;

	`QAT_ASSERT_NOW(a_quote_in_token, quote_q, tok_q, "quoted run open without a token")
	`QAT_ASSERT_NOW(a_nest_in_quote, nest_q != '0, quote_q, "nest count live outside a run")
	`QAT_ASSERT_NOW(a_no_push_nodelim, accept && !cfg.has_delim, !push, "word pushed without delimiter class")
	`QAT_ASSERT_NEXT(a_last_clears, accept && in_data.string_last, !tok_q && !quote_q && nest_q == '0, "state kept past string end")

endmodule

// File: hw/rtl/qat_fifo.sv
// Short result queue between the front end and the output channel.
// Depends on qat_pkg and quote_aware_tokenizer_defines.svh.
`include "quote_aware_tokenizer_defines.svh"

module qat_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qat_pkg::out_word_t push_word,
	output logic               space,
	output logic               out_valid,
	input  logic               out_ready,
	output qat_pkg::out_word_t out_data
);
	import qat_pkg::*;

	out_word_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop;

	assign space     = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`QAT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
	`QAT_ASSERT_NOW(a_no_overflow, push, space, "push into full queue")
	`QAT_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count missed a push")
	`QAT_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "count missed a pop")

endmodule

// File: hw/rtl/quote_aware_tokenizer.sv
// Quote-aware string tokenizer, top level.
// Depends on qat_pkg, qat_regs, qat_front and qat_fifo.
//
// Usage:
// - Input channel (in_valid/in_ready/in_data) takes one string byte per word,
//   with string_last marking the final byte of a string.
// - Output channel (out_valid/out_ready/out_data) gives zero or one word per
//   input byte: token bytes with a first-of-token flag, plus a bare end marker
//   when the final byte yields no character.
// - The APB port writes the eight 64-bit class map words at byte address 8*i;
//   write only while the block is idle.
// - Throughput: one byte per cycle while the queue has space; the per-byte state
//   update is combinational logic in the front end, registered on accept.
// - A result is written into the four-word queue when its byte is accepted and
//   is given on out_data from the queue's registers.
// - When the receiver stalls, the queue fills and in_ready drops once it holds
//   four words; nothing is lost.
// - Reset clears the class map (no delimiter class, so no output), the token
//   and quote state, and empties the queue.
module quote_aware_tokenizer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  qat_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output qat_pkg::out_word_t         out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qat_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready
);
	import qat_pkg::*;

	map_cfg_t  cfg;
	logic      space, push;
	out_word_t push_word;

	qat_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.space     (space),
		.push      (push),
		.push_word (push_word)
	);

	qat_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: bench/tb.sv
// Self-checking bench for quote_aware_tokenizer: directed string table, then random maps and strings.
// Each output word is checked against a bench-side tokenizer tracker or a typed word from the directed table.
// Depends on qat_pkg and the quote_aware_tokenizer RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qat_pkg::*;

	typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_TYPED} row_kind_t;

	typedef enum logic [2:0] {
		MAP_MIXED, MAP_SPARSE, MAP_EMPTY, MAP_ALL_QUOTE, MAP_ALL_DROP, MAP_ALL_KEEP, MAP_RAW
	} map_style_t;

	typedef struct {
		logic [7:0] ch;
		logic       is_last;
		row_kind_t  kind;
		out_word_t  want;
	} dir_row_t;

	localparam int DIR_ROWS = 25;
	localparam int DIR_RESET_ROWS = 3;
	localparam int USEFUL_TARGET = 1800;
	localparam int QUIET_AFTER = 1600;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{8'h00, 1'b0, ROW_NONE,  11'h0},
		'{8'h41, 1'b0, ROW_NONE,  11'h0},
		'{8'hFF, 1'b1, ROW_NONE,  11'h0},
		'{8'h61, 1'b0, ROW_PRED,  11'h0},
		'{8'h62, 1'b0, ROW_PRED,  11'h0},
		'{8'h2C, 1'b0, ROW_TYPED, {8'h2C, 3'b110}},
		'{8'h63, 1'b0, ROW_PRED,  11'h0},
		'{8'h20, 1'b0, ROW_NONE,  11'h0},
		'{8'h64, 1'b1, ROW_PRED,  11'h0},
		'{8'h20, 1'b1, ROW_TYPED, {8'h00, 3'b001}},
		'{8'h22, 1'b0, ROW_PRED,  11'h0},
		'{8'h20, 1'b0, ROW_PRED,  11'h0},
		'{8'h2C, 1'b0, ROW_PRED,  11'h0},
		'{8'h22, 1'b0, ROW_PRED,  11'h0},
		'{8'h2C, 1'b1, ROW_TYPED, {8'h2C, 3'b111}},
		'{8'h28, 1'b0, ROW_PRED,  11'h0},
		'{8'h28, 1'b0, ROW_PRED,  11'h0},
		'{8'h5B, 1'b0, ROW_PRED,  11'h0},
		'{8'h29, 1'b0, ROW_PRED,  11'h0},
		'{8'h29, 1'b0, ROW_PRED,  11'h0},
		'{8'h7B, 1'b0, ROW_PRED,  11'h0},
		'{8'h20, 1'b1, ROW_PRED,  11'h0},
		'{8'hFF, 1'b0, ROW_TYPED, {8'hFF, 3'b110}},
		'{8'h00, 1'b1, ROW_TYPED, {8'h00, 3'b001}},
		'{8'h5D, 1'b1, ROW_PRED,  11'h0}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_word_t            in_data;
	logic                out_valid;
	logic                out_ready;
	out_word_t           out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [63:0]         pwdata;
	logic [63:0]         prdata;
	logic                pready;

	class_map_t           map_shadow = '0;
	logic                 tok_open = 1'b0;
	logic                 quote_open = 1'b0;
	logic [7:0]           quote_char = 8'h00;
	logic [NEST_BITS-1:0] nest_depth = '0;

	out_word_t tokens_due[$];
	in_word_t  pending[$];
	row_kind_t cur_kind = ROW_PRED;
	out_word_t cur_want = '0;
	int        errors = 0;
	bit        quiet = 1'b0;
	bit        tx_gaps = 1'b1;
	bit        rx_calm = 1'b0;

	quote_aware_tokenizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("tb failed");
		$finish;
	end

	function automatic char_class_t class_lookup(input logic [7:0] ch);
		return char_class_t'(map_shadow[ch[7:5]][{ch[4:0], 1'b0} +: 2]);
	endfunction

	function automatic void put_class(ref class_map_t m, input logic [7:0] ch,
		input char_class_t c);
		m[ch[7:5]][{ch[4:0], 1'b0} +: 2] = c;
	endfunction

	function automatic bit delim_present(input class_map_t m);
		logic [63:0] lo;
		logic [63:0] hi;
		for (int i = 0; i < MAP_REGS; i++) begin
			lo = m[i] & PAIR_LOW_BITS;
			hi = (m[i] >> 1) & PAIR_LOW_BITS;
			if ((lo ^ hi) != 64'd0) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void bracket_pair(input logic [7:0] open_ch, output logic is_br,
		output logic [7:0] close_ch);
		is_br = 1'b1;
		close_ch = 8'h00;
		if (open_ch == CH_LPAREN) close_ch = CH_RPAREN;
		else if (open_ch == CH_LBRACK) close_ch = CH_RBRACK;
		else if (open_ch == CH_LBRACE) close_ch = CH_RBRACE;
		else is_br = 1'b0;
	endfunction

	function automatic void drop_tracking();
		tok_open = 1'b0;
		quote_open = 1'b0;
		quote_char = 8'h00;
		nest_depth = '0;
	endfunction

	task automatic predict_token(input in_word_t w, output bit fires, output out_word_t r);
		logic [7:0] ch;
		logic       fire;
		logic       lead;
		logic       is_br;
		logic [7:0] close_ch;
		ch = w.byte_in;
		fire = 1'b0;
		lead = 1'b0;
		r = '0;
		fires = 1'b0;
		if (!delim_present(map_shadow)) begin
			drop_tracking();
			return;
		end
		if (quote_open) begin
			bracket_pair(quote_char, is_br, close_ch);
			fire = 1'b1;
			if (is_br) begin
				if (ch == quote_char) begin
					if (nest_depth != NEST_MAX) nest_depth = nest_depth + 1'b1;
				end else if (ch == close_ch) begin
					if (nest_depth != '0) nest_depth = nest_depth - 1'b1;
					if (nest_depth == '0) quote_open = 1'b0;
				end
			end else if (ch == quote_char) begin
				quote_open = 1'b0;
			end
		end else begin
			case (class_lookup(ch))
				CLS_ORD: begin
					fire = 1'b1;
					lead = !tok_open;
					tok_open = 1'b1;
				end
				CLS_DROP: tok_open = 1'b0;
				CLS_KEEP: begin
					fire = 1'b1;
					lead = 1'b1;
					tok_open = 1'b0;
				end
				default: begin
					fire = 1'b1;
					lead = !tok_open;
					tok_open = 1'b1;
					quote_open = 1'b1;
					quote_char = ch;
					bracket_pair(ch, is_br, close_ch);
					nest_depth = is_br ? NEST_BITS'(1) : '0;
				end
			endcase
		end
		if (w.string_last) drop_tracking();
		fires = fire || w.string_last;
		r.token_byte = fire ? ch : 8'h00;
		r.token_first = fire && lead;
		r.has_byte = fire;
		r.string_end = w.string_last;
	endtask

	task automatic flag_mismatch(input string what, input out_word_t got, input out_word_t want);
		string bad;
		bad = "";
		if (got.token_byte !== want.token_byte) bad = {bad, " token_byte"};
		if (got.token_first !== want.token_first) bad = {bad, " token_first"};
		if (got.has_byte !== want.has_byte) bad = {bad, " has_byte"};
		if (got.string_end !== want.string_end) bad = {bad, " string_end"};
		$display("mismatch (%s):%s got %03h want %03h at %0t", what, bad, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		out_word_t r;
		out_word_t want;
		bit        fires;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_token(in_data, fires, r);
				if (cur_kind == ROW_TYPED) tokens_due = {tokens_due, cur_want};
				else if (cur_kind == ROW_PRED && fires) tokens_due = {tokens_due, r};
			end
			if (out_valid && out_ready) begin
				if (tokens_due.size() == 0) begin
					flag_mismatch("unexpected word", out_data, '0);
				end else begin
					want = tokens_due.pop_front();
					if (out_data !== want) flag_mismatch("token word", out_data, want);
				end
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input in_word_t w, input row_kind_t k, input out_word_t want);
		if (!quiet && tx_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end else if (!quiet && $urandom_range(0, 199) == 0) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while (tokens_due.size() != 0) @(negedge clk);
		end
		cur_kind = k;
		cur_want = want;
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// drain all expected output words, then hold with the input idle
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tokens_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		map_shadow[idx] = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_map(input class_map_t m);
		for (int i = 0; i < MAP_REGS; i++) apb_write(i, m[i]);
	endtask

	function automatic class_map_t make_map(input map_style_t style);
		class_map_t m;
		int         r;
		m = '0;
		case (style)
			MAP_MIXED: begin
				for (int ch = 0; ch < 256; ch++) begin
					r = $urandom_range(0, 9);
					if (r < 7) put_class(m, ch[7:0], CLS_ORD);
					else if (r == 7) put_class(m, ch[7:0], CLS_DROP);
					else if (r == 8) put_class(m, ch[7:0], CLS_KEEP);
					else put_class(m, ch[7:0], CLS_QUOTE);
				end
				put_class(m, 8'h20, CLS_DROP);
				put_class(m, 8'h22, CLS_QUOTE);
				if ($urandom_range(0, 1)) put_class(m, CH_LPAREN, CLS_QUOTE);
				if ($urandom_range(0, 1)) put_class(m, CH_LBRACK, CLS_QUOTE);
				if ($urandom_range(0, 1)) put_class(m, CH_LBRACE, CLS_QUOTE);
			end
			MAP_SPARSE: begin
				put_class(m, 8'($urandom_range(0, 255)),
					$urandom_range(0, 1) ? CLS_DROP : CLS_KEEP);
				repeat ($urandom_range(0, 3)) put_class(m, 8'($urandom_range(0, 255)), CLS_QUOTE);
				if ($urandom_range(0, 1)) put_class(m, CH_LPAREN, CLS_QUOTE);
				if ($urandom_range(0, 1)) put_class(m, CH_LBRACE, CLS_QUOTE);
			end
			MAP_EMPTY: begin
				repeat ($urandom_range(0, 4)) put_class(m, 8'($urandom_range(0, 255)), CLS_QUOTE);
			end
			MAP_ALL_QUOTE: m = '1;
			MAP_ALL_DROP: for (int i = 0; i < MAP_REGS; i++) m[i] = PAIR_LOW_BITS;
			MAP_ALL_KEEP: for (int i = 0; i < MAP_REGS; i++) m[i] = PAIR_LOW_BITS << 1;
			default: for (int i = 0; i < MAP_REGS; i++) m[i] = {$urandom, $urandom};
		endcase
		return m;
	endfunction

	function automatic logic [7:0] pick_of_class(input char_class_t c);
		logic [7:0] start;
		logic [7:0] ch;
		start = 8'($urandom_range(0, 255));
		for (int i = 0; i < 256; i++) begin
			ch = start + 8'(i);
			if (class_lookup(ch) == c) return ch;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic build_string(ref in_word_t q[$]);
		logic [7:0] s[$];
		logic [7:0] open_ch;
		logic [7:0] close_ch;
		logic [7:0] ch;
		logic       is_br;
		int         shape;
		int         depth;
		int         r;
		in_word_t   w;
		shape = $urandom_range(0, 9);
		if (shape <= 1) begin
			repeat ($urandom_range(1, 30)) s = {s, 8'($urandom_range(0, 255))};
		end else begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 3))
					0: repeat ($urandom_range(1, 5)) s = {s, pick_of_class(CLS_ORD)};
					1: s = {s, pick_of_class($urandom_range(0, 1) ? CLS_DROP : CLS_KEEP)};
					default: begin
						r = $urandom_range(0, 5);
						if (r == 0) open_ch = CH_LPAREN;
						else if (r == 1) open_ch = CH_LBRACK;
						else if (r == 2) open_ch = CH_LBRACE;
						else open_ch = pick_of_class(CLS_QUOTE);
						bracket_pair(open_ch, is_br, close_ch);
						s = {s, open_ch};
						depth = 1;
						repeat ($urandom_range(0, 8)) begin
							r = $urandom_range(0, 3);
							if (is_br && r == 0) begin
								s = {s, open_ch};
								depth++;
							end else if (is_br && r == 1 && depth > 1) begin
								s = {s, close_ch};
								depth--;
							end else begin
								ch = 8'($urandom_range(0, 255));
								if (ch == open_ch || (is_br && ch == close_ch)) ch = 8'h61;
								s = {s, ch};
							end
						end
						// leave the run open on broken strings
						if (shape != 2) begin
							if (is_br) repeat (depth) s = {s, close_ch};
							else s = {s, open_ch};
						end
					end
				endcase
			end
		end
		foreach (s[i]) begin
			w.byte_in = s[i];
			w.string_last = (i == s.size() - 1);
			q = {q, w};
		end
	endtask

	// nest past saturation, then unwind through it
	task automatic deep_string(ref in_word_t q[$]);
		in_word_t w;
		w.string_last = 1'b0;
		w.byte_in = CH_LPAREN;
		repeat (260) q = {q, w};
		w.byte_in = CH_RPAREN;
		repeat (3) q = {q, w};
		w.byte_in = 8'h7A;
		q = {q, w};
		w.byte_in = CH_LPAREN;
		q = {q, w};
		w.byte_in = CH_RPAREN;
		repeat (260) q = {q, w};
		w.byte_in = 8'h71;
		w.string_last = 1'b1;
		q = {q, w};
	endtask

	initial begin
		class_map_t dir_map;
		class_map_t m;
		in_word_t   w;
		map_style_t style;
		int         useful;
		int         n;
		int         r;
		bit         lead_phase;
		bit         live;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		dir_map = '0;
		put_class(dir_map, 8'h20, CLS_DROP);
		put_class(dir_map, 8'h00, CLS_DROP);
		put_class(dir_map, 8'h2C, CLS_KEEP);
		put_class(dir_map, 8'hFF, CLS_KEEP);
		put_class(dir_map, 8'h22, CLS_QUOTE);
		put_class(dir_map, 8'h27, CLS_QUOTE);
		put_class(dir_map, CH_LPAREN, CLS_QUOTE);
		put_class(dir_map, CH_LBRACK, CLS_QUOTE);
		put_class(dir_map, CH_LBRACE, CLS_QUOTE);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_RESET_ROWS) begin
				settle();
				load_map(dir_map);
			end
			w.byte_in = dir_tab[i].ch;
			w.string_last = dir_tab[i].is_last;
			send_word(w, dir_tab[i].kind, dir_tab[i].want);
		end

		useful = 0;
		lead_phase = 1'b1;
		while (useful < USEFUL_TARGET) begin
			r = $urandom_range(0, 19);
			if (lead_phase || r < 9) style = MAP_MIXED;
			else if (r < 12) style = MAP_SPARSE;
			else if (r == 12) style = MAP_EMPTY;
			else if (r == 13) style = MAP_ALL_QUOTE;
			else if (r == 14) style = MAP_ALL_DROP;
			else if (r == 15) style = MAP_ALL_KEEP;
			else style = MAP_RAW;
			m = make_map(style);
			if (lead_phase) put_class(m, CH_LPAREN, CLS_QUOTE);
			settle();
			load_map(m);
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			live = delim_present(m);
			if (lead_phase) begin
				deep_string(pending);
				n = 600;
			end else begin
				n = live ? $urandom_range(40, 160) : $urandom_range(10, 30);
			end
			repeat (n) begin
				if (pending.size() == 0) build_string(pending);
				w = pending.pop_front();
				send_word(w, ROW_PRED, '0);
				if (live) useful++;
				quiet = (useful > QUIET_AFTER);
			end
			lead_phase = 1'b0;
		end

		in_valid <= 1'b0;
		while (tokens_due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
